@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the formatter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/itaf_pkg.sv @@
// Package of the integer to ASCII formatter: sizes, character codes,
// controller states and the command and status structs. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package itaf_pkg;

  localparam int VAL_W    = 64;
  localparam int NUM_DIG  = 20;
  localparam int DIG_W    = 4 * NUM_DIG;
  localparam int CNT_W    = 5;
  localparam int STEP_W   = 4;
  localparam int NIB_STEP = 4;

  localparam logic [1:0] MODE_UPPER = 2'd0;
  localparam logic [1:0] MODE_PTR   = 2'd2;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_X     = 8'h78;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_UA    = 8'h41;
  localparam logic [7:0] CHR_LA    = 8'h61;
  localparam logic [7:0] CHR_LPAR  = 8'h28;
  localparam logic [7:0] CHR_N     = 8'h6E;
  localparam logic [7:0] CHR_I     = 8'h69;
  localparam logic [7:0] CHR_L     = 8'h6C;
  localparam logic [7:0] CHR_RPAR  = 8'h29;

  localparam logic [CNT_W-1:0] NIL_LAST = 5'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PRE,
    ST_DIG,
    ST_NIL
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_DIG,
    PH_NIL
  } phase_t;

  typedef struct packed {
    logic   load;
    logic   conv;
    logic   skip;
    logic   emit;
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic nil;
    logic conv_last;
    logic top_zero;
    logic ndig_one;
    logic pre_none;
    logic pre_done;
    logic nil_done;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/integer_to_ascii_formatter_unit.sv @@
// Top level of the integer to ASCII formatter: joins controller and datapath.
// Depends on itaf_pkg, itaf_ctrl and itaf_dpath.
//
//   Channel | Direction | Handshake             | Payload
//   in_     | input     | in_valid / in_stall   | value(64, signed), hex(1), mode(2)
//   out_    | output    | out_valid / out_stall | char_code(8), last(1), char_count(5)
//
// A number is accepted in the idle state only; its beat in is followed by the conversion
// steps, the skipping of the leading zero digits and then one character beat per cycle
// while the result side does not stall. A pointer-mode zero skips the conversion and
// emits the five characters of its nil text. Reset is synchronous and active low; it
// returns the controller to idle and empties the output register. A stall on the result
// side freezes emission.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [63:0]            in_value,
  input  wire logic                          in_hex,
  input  wire logic [1:0]                    in_mode,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_char_code,
  output logic                               out_last,
  output logic [4:0]                         out_char_count
);

  // Commands flow from the controller to the datapath; status flows back.
  itaf_pkg::cmd_t cmd;
  itaf_pkg::sts_t sts;

  // The controller owns the state machine and the output valid flag. It only
  // issues an emit when the output register is empty or is being drained in
  // the same cycle, so no character is ever overwritten or repeated.
  itaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // The datapath converts the magnitude into twenty four-bit digits, either
  // decimal by shift-and-add-3 or hexadecimal by plain nibble shifts, four
  // bits per cycle, then drops leading zeros and hands out characters.
  itaf_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_hex         (in_hex),
    .in_mode        (in_mode),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_char_code  (out_char_code),
    .out_last       (out_last),
    .out_char_count (out_char_count)
  );

endmodule

`default_nettype wire

@@ rtl/core/itaf_ctrl.sv @@
// Controller state machine of the formatter: sequences conversion, zero
// skipping and character emission. Depends on itaf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itaf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output itaf_pkg::cmd_t     cmd_o,
  input  wire itaf_pkg::sts_t sts_i
);

  itaf_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itaf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != itaf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd_o       = '0;
    cmd_o.phase = itaf_pkg::PH_DIG;
    case (state_r)
      itaf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = itaf_pkg::ST_CONV;
        end
      end
      itaf_pkg::ST_CONV: begin
        if (sts_i.nil) begin
          state_nxt = itaf_pkg::ST_NIL;
        end else begin
          cmd_o.conv = 1'b1;
          if (sts_i.conv_last) begin
            state_nxt = itaf_pkg::ST_SKIP;
          end
        end
      end
      itaf_pkg::ST_SKIP: begin
        if (sts_i.top_zero && !sts_i.ndig_one) begin
          cmd_o.skip = 1'b1;
        end else if (sts_i.pre_none) begin
          state_nxt = itaf_pkg::ST_DIG;
        end else begin
          state_nxt = itaf_pkg::ST_PRE;
        end
      end
      itaf_pkg::ST_PRE: begin
        cmd_o.phase = itaf_pkg::PH_PRE;
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pre_done) begin
            state_nxt = itaf_pkg::ST_DIG;
          end
        end
      end
      itaf_pkg::ST_DIG: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.ndig_one) begin
            state_nxt = itaf_pkg::ST_IDLE;
          end
        end
      end
      itaf_pkg::ST_NIL: begin
        cmd_o.phase = itaf_pkg::PH_NIL;
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.nil_done) begin
            state_nxt = itaf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itaf_pkg::ST_IDLE;
      end
    endcase
    if (cmd_o.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  `ASSERT_IMP(a_emit_slot, clk, rst_n, cmd_o.emit, !out_valid_r || !out_stall)
  `ASSERT_NXT(a_accept_conv, clk, rst_n, in_valid && !in_stall, state_r == itaf_pkg::ST_CONV)
  `ASSERT_NXT(a_conv_end, clk, rst_n,
              state_r == itaf_pkg::ST_CONV && !sts_i.nil && sts_i.conv_last,
              state_r == itaf_pkg::ST_SKIP)

endmodule

`default_nettype wire

@@ rtl/core/itaf_dpath.sv @@
// Datapath of the formatter: digit register with shift-and-add-3 conversion,
// magnitude shifter, counters and the output character register.
// Depends on itaf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itaf_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [itaf_pkg::VAL_W-1:0]    in_value,
  input  wire logic                          in_hex,
  input  wire logic [1:0]                    in_mode,
  input  wire itaf_pkg::cmd_t                cmd_i,
  output itaf_pkg::sts_t                     sts_o,
  output logic [7:0]                         out_char_code,
  output logic                               out_last,
  output logic [itaf_pkg::CNT_W-1:0]         out_char_count
);

  localparam int SH_W = itaf_pkg::DIG_W + itaf_pkg::VAL_W;

  logic [itaf_pkg::DIG_W-1:0]  dig_r, dig_nxt;
  logic [itaf_pkg::VAL_W-1:0]  mag_r, mag_nxt;
  logic [itaf_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [itaf_pkg::CNT_W-1:0]  ndig_r, ndig_nxt;
  logic [itaf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic neg_r, neg_nxt;
  logic ptr_r, ptr_nxt;
  logic dec_r, dec_nxt;
  logic upper_r, upper_nxt;
  logic nil_r, nil_nxt;
  logic [7:0]                 char_r, char_nxt;
  logic                       last_r, last_nxt;
  logic [itaf_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [SH_W-1:0]            dd_res;
  logic                       in_ptr, in_neg;

  // Four shift-and-add-3 steps: each digit of five or more gets three added
  // before the whole word moves up by one bit.
  function automatic logic [SH_W-1:0] dd_step(input logic [SH_W-1:0] w);
    logic [SH_W-1:0] t;
    t = w;
    for (int s = 0; s < itaf_pkg::NIB_STEP; s++) begin
      for (int j = 0; j < itaf_pkg::NUM_DIG; j++) begin
        if (t[itaf_pkg::VAL_W + 4*j +: 4] >= 4'd5) begin
          t[itaf_pkg::VAL_W + 4*j +: 4] = t[itaf_pkg::VAL_W + 4*j +: 4] + 4'd3;
        end
      end
      t = {t[SH_W-2:0], 1'b0};
    end
    return t;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = itaf_pkg::CHR_ZERO + {4'd0, d};
    end else if (up) begin
      c = itaf_pkg::CHR_UA + {4'd0, d - 4'd10};
    end else begin
      c = itaf_pkg::CHR_LA + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

  function automatic logic [7:0] nil_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = itaf_pkg::CHR_LPAR;
      3'd1:    c = itaf_pkg::CHR_N;
      3'd2:    c = itaf_pkg::CHR_I;
      3'd3:    c = itaf_pkg::CHR_L;
      default: c = itaf_pkg::CHR_RPAR;
    endcase
    return c;
  endfunction

  assign in_ptr = (in_mode == itaf_pkg::MODE_PTR);
  assign in_neg = !in_ptr && in_value[itaf_pkg::VAL_W-1];
  assign dd_res = dd_step({dig_r, mag_r});

  always_comb begin
    dig_nxt   = dig_r;
    mag_nxt   = mag_r;
    step_nxt  = step_r;
    ndig_nxt  = ndig_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    ptr_nxt   = ptr_r;
    dec_nxt   = dec_r;
    upper_nxt = upper_r;
    nil_nxt   = nil_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    count_nxt = count_r;

    if (cmd_i.load) begin
      dig_nxt   = '0;
      mag_nxt   = in_neg ? (~in_value + 64'd1) : in_value;
      step_nxt  = '0;
      ndig_nxt  = itaf_pkg::CNT_W'(itaf_pkg::NUM_DIG);
      cnt_nxt   = '0;
      neg_nxt   = in_neg;
      ptr_nxt   = in_ptr;
      dec_nxt   = !in_ptr && !in_hex;
      upper_nxt = (in_mode == itaf_pkg::MODE_UPPER);
      nil_nxt   = in_ptr && (in_value == '0);
    end

    if (cmd_i.conv) begin
      if (dec_r) begin
        {dig_nxt, mag_nxt} = dd_res;
      end else begin
        {dig_nxt, mag_nxt} = {dig_r, mag_r} << 4;
      end
      step_nxt = step_r + 4'd1;
    end

    if (cmd_i.skip) begin
      dig_nxt  = dig_r << 4;
      ndig_nxt = ndig_r - 5'd1;
    end

    if (cmd_i.emit) begin
      cnt_nxt  = cnt_r + 5'd1;
      last_nxt = 1'b0;
      case (cmd_i.phase)
        itaf_pkg::PH_PRE: begin
          if (!ptr_r) begin
            char_nxt = itaf_pkg::CHR_MINUS;
          end else if (cnt_r == 5'd0) begin
            char_nxt = itaf_pkg::CHR_ZERO;
          end else begin
            char_nxt = itaf_pkg::CHR_X;
          end
        end
        itaf_pkg::PH_DIG: begin
          char_nxt = digit_char(dig_r[itaf_pkg::DIG_W-1 -: 4], upper_r);
          last_nxt = (ndig_r == 5'd1);
          dig_nxt  = dig_r << 4;
          ndig_nxt = ndig_r - 5'd1;
        end
        itaf_pkg::PH_NIL: begin
          char_nxt = nil_char(cnt_r[2:0]);
          last_nxt = (cnt_r == itaf_pkg::NIL_LAST);
        end
        default: begin
          char_nxt = itaf_pkg::CHR_ZERO;
        end
      endcase
      count_nxt = last_nxt ? (cnt_r + 5'd1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    mag_r   <= mag_nxt;
    step_r  <= step_nxt;
    ndig_r  <= ndig_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    ptr_r   <= ptr_nxt;
    dec_r   <= dec_nxt;
    upper_r <= upper_nxt;
    nil_r   <= nil_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    count_r <= count_nxt;
  end

  always_comb begin
    sts_o.nil       = nil_r;
    sts_o.conv_last = (step_r == '1);
    sts_o.top_zero  = (dig_r[itaf_pkg::DIG_W-1 -: 4] == 4'd0);
    sts_o.ndig_one  = (ndig_r == 5'd1);
    sts_o.pre_none  = !ptr_r && !neg_r;
    sts_o.pre_done  = !ptr_r || (cnt_r == 5'd1);
    sts_o.nil_done  = (cnt_r == itaf_pkg::NIL_LAST);
  end

  assign out_char_code  = char_r;
  assign out_last       = last_r;
  assign out_char_count = count_r;

  `ASSERT_IMP(a_dig_left, clk, rst_n,
              cmd_i.emit && cmd_i.phase == itaf_pkg::PH_DIG, ndig_r != 5'd0)
  `ASSERT_IMP(a_skip_room, clk, rst_n, cmd_i.skip, ndig_r > 5'd1)
  `ASSERT_NXT(a_load_clear, clk, rst_n, cmd_i.load, cnt_r == '0 && step_r == '0)

endmodule

`default_nettype wire

@@ tb/sv/integer_to_ascii_formatter_unit_checker.sv @@
// Checker for the integer to ASCII formatter: predicts the characters of every
// accepted number and compares them, beat by beat, with the result channel.
// Depends on itaf_pkg for sizes, character codes and mode codes.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit_checker
  import itaf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_hex,
  input  logic [1:0]              in_mode,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [7:0]              out_char_code,
  input  logic                    out_last,
  input  logic [CNT_W-1:0]        out_char_count,
  output int                      mismatch_count,
  output int                      pending_count
);

  typedef struct packed {
    logic [7:0]       code;
    logic             last;
    logic [CNT_W-1:0] count;
  } char_beat_t;

  char_beat_t expected_chars[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic [7:0] alpha);
    if (d < 4'd10) begin
      return CHR_ZERO + {4'd0, d};
    end
    return alpha + {4'd0, d} - 8'd10;
  endfunction

  // Appends the expected beats of one number to the queue.
  task automatic predict_text(input logic [VAL_W-1:0] raw, input logic hex_sel,
                              input logic [1:0] mode_sel);
    logic [7:0]       text[$];
    logic [7:0]       digs[$];
    logic [VAL_W-1:0] mag;
    logic [VAL_W-1:0] base;
    logic [7:0]       alpha;
    char_beat_t       beat;
    int               n;
    if (mode_sel == MODE_PTR && raw == '0) begin
      text = '{CHR_LPAR, CHR_N, CHR_I, CHR_L, CHR_RPAR};
    end else begin
      if (mode_sel == MODE_PTR) begin
        text.push_back(CHR_ZERO);
        text.push_back(CHR_X);
        mag   = raw;
        base  = 64'd16;
        alpha = CHR_LA;
      end else begin
        if (raw[VAL_W-1]) begin
          text.push_back(CHR_MINUS);
          mag = ~raw + 64'd1;
        end else begin
          mag = raw;
        end
        base  = hex_sel ? 64'd16 : 64'd10;
        alpha = (mode_sel == MODE_UPPER) ? CHR_UA : CHR_LA;
      end
      do begin
        digs.push_front(digit_char(4'(mag % base), alpha));
        mag = mag / base;
      end while (mag != '0 && digs.size() < NUM_DIG);
      foreach (digs[i]) text.push_back(digs[i]);
    end
    n = text.size();
    foreach (text[i]) begin
      beat.code  = text[i];
      beat.last  = (i == n - 1);
      beat.count = (i == n - 1) ? CNT_W'(n) : '0;
      expected_chars.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_text(in_value, in_hex, in_mode);
      end
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected beat code=%02h last=%0d count=%0d", $realtime,
                     out_char_code, out_last, out_char_count);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_char_code !== want.code || out_last !== want.last ||
              out_char_count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: exp code %02h last %0d count %0d, got %02h %0d %0d",
                       $realtime, want.code, want.last, want.count,
                       out_char_code, out_last, out_char_count);
            end
          end
        end
      end
    end
    pending_count = expected_chars.size();
  end

endmodule

@@ tb/sv/integer_to_ascii_formatter_unit_tb.sv @@
// Top of the integer to ASCII formatter testbench: clock, reset, stimulus and
// verdict. Depends on itaf_pkg, the formatter RTL and the checker module.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit_tb;
  import itaf_pkg::*;

  // Mode codes the package does not name. The spare code three must behave
  // exactly as the signed lowercase mode.
  localparam logic [1:0] MODE_LOWER = 2'd1;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int RESET_CYCLES = 11;
  localparam int LONG_HOLD    = 400;
  // Margin after the last phase that comfortably covers anything still in flight.
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 120;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    in_hex = 1'b0;
  logic [1:0]              in_mode = MODE_UPPER;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [7:0]              out_char_code;
  logic                    out_last;
  logic [CNT_W-1:0]        out_char_count;

  int mismatch_count;
  int pending_count;

  // Idle percentages of the two sides; the stimulus process changes them
  // between phases while the block is empty.
  int send_idle_pct = 20;
  int recv_idle_pct = 88;

  // The long hold-off is requested by the stimulus process and carried out,
  // cycle by cycle, by the result-side process, which alone marks it served.
  logic hold_request = 1'b0;
  logic hold_served  = 1'b0;

  integer_to_ascii_formatter_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_hex         (in_hex),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last       (out_last),
    .out_char_count (out_char_count)
  );

  integer_to_ascii_formatter_unit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_hex         (in_hex),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last       (out_last),
    .out_char_count (out_char_count),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever begin
      #2 clk = ~clk;
    end
  end

  // A generous fixed limit: the slowest honest run is well under a tenth of it.
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side. Every falling edge decides the stall for the coming rising
  // edge, so a stall lands on every phase of the character stream. Once the
  // long hold-off is requested the stall stays high until the hold is marked served,
  // during which the block fills up and has to stall its input.
  initial begin : result_side
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        out_stall <= 1'b1;
        held++;
        if (held == LONG_HOLD) begin
          hold_served = 1'b1;
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one number and returns at the falling edge after the beat that
  // carried it was accepted. It is entered at a falling edge, and in_valid
  // gets exactly one assignment per edge, so a valid that stays high for a
  // back-to-back number is never lowered and raised in the same step.
  task automatic push_number(input logic [VAL_W-1:0] v, input logic h, input logic [1:0] m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_hex   <= h;
    in_mode  <= m;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  // Withdraws the sender and waits until every predicted character has come
  // out. At least one edge passes, so a following push_number never assigns
  // in_valid in the same step as the withdrawal.
  task automatic settle_sender();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_count != 0);
  endtask

  // Random values of spread sizes: most have few digits so that leading zero
  // skipping and short texts are well exercised, some are full width, and the
  // extremes turn up now and then.
  function automatic logic [VAL_W-1:0] random_value();
    logic [VAL_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = VAL_W'($urandom_range(99));
      1: v = -VAL_W'($urandom_range(99));
      2: v = {1'b1, {(VAL_W-1){1'b0}}};
      3: v = {1'b0, {(VAL_W-1){1'b1}}};
      4: v = v >> $urandom_range(VAL_W-1);
      5: v = -(v >> $urandom_range(VAL_W-1));
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_phase(input int items);
    repeat (items) begin
      push_number(random_value(), 1'($urandom_range(1)), 2'($urandom_range(3)));
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed numbers: zero in every mode, the pointer-style nil text, the
    // most negative value with its magnitude of two to the sixty-third, the
    // largest positive value, the spare mode, and a pointer asked for in
    // decimal, which must still come out in hexadecimal.
    push_number('0, 1'b0, MODE_UPPER);
    push_number('0, 1'b1, MODE_LOWER);
    push_number('0, 1'b0, MODE_PTR);
    push_number('0, 1'b1, MODE_PTR);
    push_number('0, 1'b0, MODE_SPARE);
    push_number({1'b1, {(VAL_W-1){1'b0}}}, 1'b0, MODE_UPPER);
    push_number({1'b1, {(VAL_W-1){1'b0}}}, 1'b1, MODE_LOWER);
    push_number({1'b1, {(VAL_W-1){1'b0}}}, 1'b1, MODE_PTR);
    push_number({1'b0, {(VAL_W-1){1'b1}}}, 1'b0, MODE_UPPER);
    push_number({1'b0, {(VAL_W-1){1'b1}}}, 1'b1, MODE_UPPER);
    push_number('1, 1'b0, MODE_LOWER);
    push_number('1, 1'b1, MODE_UPPER);
    push_number('1, 1'b0, MODE_PTR);
    push_number(64'h0000_0000_00AB_CDEF, 1'b1, MODE_SPARE);
    push_number(64'h0000_0000_00AB_CDEF, 1'b1, MODE_UPPER);
    push_number(64'h0000_0000_0000_1234, 1'b0, MODE_PTR);
    push_number(64'hFEDC_BA98_7654_3210, 1'b1, MODE_UPPER);
    push_number(64'h7EDC_BA98_7654_3210, 1'b1, MODE_LOWER);
    push_number(64'd1_000_000_000_000_000_000, 1'b0, MODE_SPARE);
    push_number(64'd999_999_999_999_999_999, 1'b0, MODE_UPPER);
    push_number(64'd9, 1'b0, MODE_LOWER);
    push_number(64'd15, 1'b1, MODE_UPPER);
    push_number(64'd1, 1'b1, MODE_PTR);

    // First phase: sender seldom idle, receiver mostly stalled.
    random_phase(RANDOM_ITEMS);
    settle_sender();

    // Second phase: the other way round.
    send_idle_pct = 88;
    recv_idle_pct = 20;
    random_phase(RANDOM_ITEMS);
    settle_sender();

    // Third phase: no idling on either side, apart from one long hold-off
    // on the result side at its start while numbers keep being offered.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    random_phase(RANDOM_ITEMS);
    settle_sender();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/itaf_pkg.sv
rtl/core/itaf_ctrl.sv
rtl/core/itaf_dpath.sv
rtl/core/integer_to_ascii_formatter_unit.sv
tb/sv/integer_to_ascii_formatter_unit_checker.sv
tb/sv/integer_to_ascii_formatter_unit_tb.sv
